### hdl/jesc_pkg.sv
// Shared types, constants, palette table and fixed-point helpers of the Julia escape unit.
package jesc_pkg;

	// Default values of the top-level parameters.
	localparam int ITER_LIMIT_DEF       = 128;
	localparam int PALETTE_ENTRIES_DEF  = 256;
	localparam int PIXEL_COORD_BITS_DEF = 10;

	// Fixed-point format: signed Q4.28 in 32 bits, wide intermediates in 48 bits.
	localparam int Q_FRAC = 28;
	localparam int WIDE_W = 48;

	localparam logic signed [WIDE_W-1:0] Q_MAX_W      = 48'sd2147483647;
	localparam logic signed [WIDE_W-1:0] Q_MIN_W      = -48'sd2147483648;
	localparam logic signed [WIDE_W-1:0] ESCAPE_BOUND = 48'sd1073741824;

	localparam logic [31:0] ARGB_BLACK = 32'hFF00_0000;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_X_MIN    = 3'd0,
		REG_Y_MIN    = 3'd1,
		REG_X_STEP   = 3'd2,
		REG_Y_STEP   = 3'd3,
		REG_C_REAL   = 3'd4,
		REG_C_IMAG   = 3'd5,
		REG_ITER_CAP = 3'd6,
		REG_PAL_SHFT = 3'd7
	} jesc_reg_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SMUL,
		ST_SADD,
		ST_ITMUL,
		ST_ITUPD,
		ST_PAL1,
		ST_PAL2,
		ST_EMIT
	} jesc_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic start_mul;
		logic start_load;
		logic iter_mul;
		logic iter_step;
		logic pal_sum;
		logic pal_fold;
		logic emit;
	} jesc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cap_hit;
		logic escaped;
	} jesc_sts_t;

	// Clamp a wide signed value to the Q4.28 range.
	function automatic logic signed [31:0] sat_q(input logic signed [WIDE_W-1:0] v);
		logic signed [31:0] r;
		if (v > Q_MAX_W) begin
			r = Q_MAX_W[31:0];
		end else if (v < Q_MIN_W) begin
			r = Q_MIN_W[31:0];
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Fixed colour palette, ARGB8888.
	localparam logic [31:0] COLOUR_ROM [0:255] = '{
		32'hFF000000, 32'hFF000000, 32'hFF040000, 32'hFF0C0000,
		32'hFF100000, 32'hFF180000, 32'hFF200000, 32'hFF240000,
		32'hFF2C0000, 32'hFF300000, 32'hFF380000, 32'hFF400000,
		32'hFF440000, 32'hFF4C0000, 32'hFF500000, 32'hFF580000,
		32'hFF600000, 32'hFF640000, 32'hFF6C0000, 32'hFF740000,
		32'hFF780000, 32'hFF800000, 32'hFF840000, 32'hFF8C0000,
		32'hFF940000, 32'hFF980000, 32'hFFA00000, 32'hFFA40000,
		32'hFFAC0000, 32'hFFB40000, 32'hFFB80000, 32'hFFC00000,
		32'hFFC80000, 32'hFFC80400, 32'hFFC80C00, 32'hFFCC1000,
		32'hFFCC1800, 32'hFFD01C00, 32'hFFD02400, 32'hFFD02800,
		32'hFFD43000, 32'hFFD43800, 32'hFFD83C00, 32'hFFD84400,
		32'hFFD84800, 32'hFFDC5000, 32'hFFDC5400, 32'hFFE05C00,
		32'hFFE06400, 32'hFFE06800, 32'hFFE47000, 32'hFFE47400,
		32'hFFE87C00, 32'hFFE88000, 32'hFFE88800, 32'hFFEC8C00,
		32'hFFEC9400, 32'hFFF09C00, 32'hFFF0A000, 32'hFFF0A800,
		32'hFFF4AC00, 32'hFFF4B400, 32'hFFF8B800, 32'hFFF8C000,
		32'hFFFCC800, 32'hFFFCC804, 32'hFFFCC80C, 32'hFFFCCC14,
		32'hFFFCCC1C, 32'hFFFCD024, 32'hFFFCD02C, 32'hFFFCD034,
		32'hFFFCD43C, 32'hFFFCD444, 32'hFFFCD84C, 32'hFFFCD854,
		32'hFFFCD85C, 32'hFFFCDC64, 32'hFFFCDC6C, 32'hFFFCE074,
		32'hFFFCE07C, 32'hFFFCE084, 32'hFFFCE48C, 32'hFFFCE494,
		32'hFFFCE89C, 32'hFFFCE8A4, 32'hFFFCE8AC, 32'hFFFCECB4,
		32'hFFFCECBC, 32'hFFFCF0C4, 32'hFFFCF0CC, 32'hFFFCF0D4,
		32'hFFFCF4DC, 32'hFFFCF4E4, 32'hFFFCF8EC, 32'hFFFCF8F4,
		32'hFFFCFCFC, 32'hFFFCFCF8, 32'hFFFCFCF4, 32'hFFFCFCF0,
		32'hFFFCFCE8, 32'hFFFCFCE4, 32'hFFFCFCE0, 32'hFFFCFCD8,
		32'hFFFCFCD4, 32'hFFFCFCD0, 32'hFFFCFCC8, 32'hFFFCFCC4,
		32'hFFFCFCC0, 32'hFFFCFCB8, 32'hFFFCFCB4, 32'hFFFCFCB0,
		32'hFFFCFCA8, 32'hFFFCFCA4, 32'hFFFCFCA0, 32'hFFFCFC9C,
		32'hFFFCFC94, 32'hFFFCFC90, 32'hFFFCFC8C, 32'hFFFCFC84,
		32'hFFFCFC80, 32'hFFFCFC7C, 32'hFFFCFC74, 32'hFFFCFC70,
		32'hFFFCFC6C, 32'hFFFCFC64, 32'hFFFCFC60, 32'hFFFCFC5C,
		32'hFFFCFC54, 32'hFFFCFC50, 32'hFFFCFC4C, 32'hFFFCFC48,
		32'hFFFCFC40, 32'hFFFCFC3C, 32'hFFFCFC38, 32'hFFFCFC30,
		32'hFFFCFC2C, 32'hFFFCFC28, 32'hFFFCFC20, 32'hFFFCFC1C,
		32'hFFFCFC18, 32'hFFFCFC10, 32'hFFFCFC0C, 32'hFFFCFC08,
		32'hFFFCFC00, 32'hFFFCF800, 32'hFFFCF400, 32'hFFFCF000,
		32'hFFFCE800, 32'hFFFCE400, 32'hFFFCE000, 32'hFFFCD800,
		32'hFFFCD400, 32'hFFFCD000, 32'hFFFCC800, 32'hFFFCC400,
		32'hFFFCC000, 32'hFFFCB800, 32'hFFFCB400, 32'hFFFCB000,
		32'hFFFCA800, 32'hFFFCA400, 32'hFFFCA000, 32'hFFFC9C00,
		32'hFFFC9400, 32'hFFFC9000, 32'hFFFC8C00, 32'hFFFC8400,
		32'hFFFC8000, 32'hFFFC7C00, 32'hFFFC7400, 32'hFFFC7000,
		32'hFFFC6C00, 32'hFFFC6400, 32'hFFFC6000, 32'hFFFC5C00,
		32'hFFFC5400, 32'hFFFC5000, 32'hFFFC4C00, 32'hFFFC4800,
		32'hFFFC4000, 32'hFFFC3C00, 32'hFFFC3800, 32'hFFFC3000,
		32'hFFFC2C00, 32'hFFFC2800, 32'hFFFC2000, 32'hFFFC1C00,
		32'hFFFC1800, 32'hFFFC1000, 32'hFFFC0C00, 32'hFFFC0800,
		32'hFFFC0000, 32'hFFF80000, 32'hFFF40000, 32'hFFF00000,
		32'hFFEC0000, 32'hFFE80000, 32'hFFE40000, 32'hFFE00000,
		32'hFFDC0000, 32'hFFD80000, 32'hFFD40000, 32'hFFD00000,
		32'hFFCC0000, 32'hFFC80000, 32'hFFC40000, 32'hFFC00000,
		32'hFFBC0000, 32'hFFB80000, 32'hFFB40000, 32'hFFB00000,
		32'hFFAC0000, 32'hFFA80000, 32'hFFA40000, 32'hFFA00000,
		32'hFF9C0000, 32'hFF980000, 32'hFF940000, 32'hFF900000,
		32'hFF8C0000, 32'hFF880000, 32'hFF840000, 32'hFF800000,
		32'hFF7C0000, 32'hFF780000, 32'hFF740000, 32'hFF700000,
		32'hFF6C0000, 32'hFF680000, 32'hFF640000, 32'hFF600000,
		32'hFF5C0000, 32'hFF580000, 32'hFF540000, 32'hFF500000,
		32'hFF4C0000, 32'hFF480000, 32'hFF440000, 32'hFF400000,
		32'hFF3C0000, 32'hFF380000, 32'hFF340000, 32'hFF300000,
		32'hFF2C0000, 32'hFF280000, 32'hFF240000, 32'hFF200000,
		32'hFF1C0000, 32'hFF180000, 32'hFF140000, 32'hFF100000,
		32'hFF0C0000, 32'hFF080000, 32'hFF000000, 32'hFF000000
	};

endpackage

### hdl/julia_escape_pixel_color.sv
// Top level of the Julia escape unit: configuration registers, controller and datapath.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall   | pixel_x, pixel_y
//  out     | output    | out_valid / out_stall | escape_count, pixel_argb, inside_set
//  config  | input     | APB psel / penable    | paddr, pwdata, prdata
//
// An item goes from acceptance to its result register through start point set-up (multiply
// and add), one multiply and one add, test and saturate step per iteration, a closing visit
// to the multiply state (a cap check when the count reaches the cap, else a multiply and a
// test step on escape), and palette index sum, fold and write. One item is in work at a time;
// the next can be taken in the cycle after the result register is written.
// Reset clears the controller and loads the register defaults; no clearing pass.
// A stalled result waits in the output register while the next item is worked on.
module julia_escape_pixel_color
	import jesc_pkg::*;
#(
	parameter int ITER_LIMIT       = ITER_LIMIT_DEF,
	parameter int PALETTE_ENTRIES  = PALETTE_ENTRIES_DEF,
	parameter int PIXEL_COORD_BITS = PIXEL_COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [4:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [PIXEL_COORD_BITS-1:0] pixel_x,
	input  logic [PIXEL_COORD_BITS-1:0] pixel_y,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  escape_count,
	output logic [31:0]                 pixel_argb,
	output logic                        inside_set
);

	logic signed [31:0] x_min_q;
	logic signed [31:0] y_min_q;
	logic signed [31:0] x_step_q;
	logic signed [31:0] y_step_q;
	logic signed [31:0] c_real_q;
	logic signed [31:0] c_imag_q;
	logic [7:0]         iteration_cap_q;
	logic [7:0]         palette_shift_q;

	jesc_reg_t reg_sel;
	logic      wr_en;
	jesc_cmd_t cmd;
	jesc_sts_t sts;

	assign pready  = 1'b1;
	assign reg_sel = jesc_reg_t'(paddr[4:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q         <= -32'sd402653184;
			y_min_q         <= -32'sd268435456;
			x_step_q        <= 32'sd1572864;
			y_step_q        <= 32'sd1048576;
			c_real_q        <= -32'sd187904819;
			c_imag_q        <= 32'sd72477573;
			iteration_cap_q <= 8'd128;
			palette_shift_q <= 8'd0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_X_MIN:    x_min_q         <= pwdata;
				REG_Y_MIN:    y_min_q         <= pwdata;
				REG_X_STEP:   x_step_q        <= pwdata;
				REG_Y_STEP:   y_step_q        <= pwdata;
				REG_C_REAL:   c_real_q        <= pwdata;
				REG_C_IMAG:   c_imag_q        <= pwdata;
				REG_ITER_CAP: iteration_cap_q <= pwdata[7:0];
				REG_PAL_SHFT: palette_shift_q <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (reg_sel)
			REG_X_MIN:    prdata = x_min_q;
			REG_Y_MIN:    prdata = y_min_q;
			REG_X_STEP:   prdata = x_step_q;
			REG_Y_STEP:   prdata = y_step_q;
			REG_C_REAL:   prdata = c_real_q;
			REG_C_IMAG:   prdata = c_imag_q;
			REG_ITER_CAP: prdata = {24'd0, iteration_cap_q};
			REG_PAL_SHFT: prdata = {24'd0, palette_shift_q};
			default:      prdata = '0;
		endcase
	end

	jesc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	jesc_dpath #(
		.ITER_LIMIT       (ITER_LIMIT),
		.PALETTE_ENTRIES  (PALETTE_ENTRIES),
		.PIXEL_COORD_BITS (PIXEL_COORD_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.x_min         (x_min_q),
		.y_min         (y_min_q),
		.x_step        (x_step_q),
		.y_step        (y_step_q),
		.c_real        (c_real_q),
		.c_imag        (c_imag_q),
		.iteration_cap (iteration_cap_q),
		.palette_shift (palette_shift_q),
		.escape_count  (escape_count),
		.pixel_argb    (pixel_argb),
		.inside_set    (inside_set)
	);

endmodule

### hdl/jesc_ctrl.sv
// Controller state machine that sequences start point, escape iterations and colour lookup.
module jesc_ctrl
	import jesc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  jesc_sts_t sts,
	output jesc_cmd_t cmd
);

	jesc_state_t state_q;
	jesc_state_t state_d;
	logic        out_valid_q;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SMUL;
				end
			end
			ST_SMUL: begin
				state_d = ST_SADD;
			end
			ST_SADD: begin
				state_d = ST_ITMUL;
			end
			ST_ITMUL: begin
				state_d = sts.cap_hit ? ST_PAL1 : ST_ITUPD;
			end
			ST_ITUPD: begin
				state_d = sts.escaped ? ST_PAL1 : ST_ITMUL;
			end
			ST_PAL1: begin
				state_d = ST_PAL2;
			end
			ST_PAL2: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			ST_SMUL: begin
				cmd.start_mul = 1'b1;
			end
			ST_SADD: begin
				cmd.start_load = 1'b1;
			end
			ST_ITMUL: begin
				cmd.iter_mul = !sts.cap_hit;
			end
			ST_ITUPD: begin
				cmd.iter_step = !sts.escaped;
			end
			ST_PAL1: begin
				cmd.pal_sum = 1'b1;
			end
			ST_PAL2: begin
				cmd.pal_fold = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = !out_valid_q || !out_stall;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State register and output item flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// An accepted item always starts the start-point multiply.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_SMUL))
		else $error("accepted item did not start the start-point multiply");

	// A result never overwrites an item that is still held back.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid_q && out_stall))
		else $error("result written over a stalled item");

	// The output flag only rises after a result was written.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.emit))
		else $error("output valid rose without a written result");

endmodule

### hdl/jesc_dpath.sv
// Datapath: start point, Q4.28 escape iteration, palette index fold and result register.
module jesc_dpath
	import jesc_pkg::*;
#(
	parameter int ITER_LIMIT       = ITER_LIMIT_DEF,
	parameter int PALETTE_ENTRIES  = PALETTE_ENTRIES_DEF,
	parameter int PIXEL_COORD_BITS = PIXEL_COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  jesc_cmd_t                   cmd,
	output jesc_sts_t                   sts,
	input  logic [PIXEL_COORD_BITS-1:0] pixel_x,
	input  logic [PIXEL_COORD_BITS-1:0] pixel_y,
	input  logic signed [31:0]          x_min,
	input  logic signed [31:0]          y_min,
	input  logic signed [31:0]          x_step,
	input  logic signed [31:0]          y_step,
	input  logic signed [31:0]          c_real,
	input  logic signed [31:0]          c_imag,
	input  logic [7:0]                  iteration_cap,
	input  logic [7:0]                  palette_shift,
	output logic [7:0]                  escape_count,
	output logic [31:0]                 pixel_argb,
	output logic                        inside_set
);

	localparam int CNT_W  = $clog2(ITER_LIMIT + 1);
	localparam int CAP_W  = (CNT_W > 8) ? CNT_W : 8;
	localparam int SUM_W  = CAP_W + 1;
	localparam int RK     = SUM_W + 9;
	localparam int RECIP  = (1 << RK) / PALETTE_ENTRIES;
	localparam int PROD_W = SUM_W + RK;
	localparam int SPX_W  = PIXEL_COORD_BITS + 33;

	logic [PIXEL_COORD_BITS-1:0] px_q;
	logic [PIXEL_COORD_BITS-1:0] py_q;
	logic signed [SPX_W-1:0]     prodx_q;
	logic signed [SPX_W-1:0]     prody_q;
	logic signed [31:0]          zx_q;
	logic signed [31:0]          zy_q;
	logic signed [63:0]          pxx_q;
	logic signed [63:0]          pyy_q;
	logic signed [63:0]          pxy_q;
	logic [CNT_W-1:0]            count_q;
	logic                        inside_q;
	logic [SUM_W-1:0]            n_q;
	logic [SUM_W-1:0]            q_q;
	logic [SUM_W-1:0]            r0_q;
	logic [7:0]                  escape_count_q;
	logic [31:0]                 pixel_argb_q;
	logic                        inside_set_q;

	logic [CAP_W-1:0]          cap;
	logic [CAP_W-1:0]          count_ext;
	logic                      cap_hit;
	logic                      escaped;
	logic signed [WIDE_W-1:0]  zx2;
	logic signed [WIDE_W-1:0]  zy2;
	logic signed [WIDE_W-1:0]  zxy2;
	logic signed [WIDE_W-1:0]  mag;
	logic [SUM_W-1:0]          pal_sum;
	logic [PROD_W-1:0]         recip_prod;
	logic [SUM_W-1:0]          pal_idx;

	// Effective cap and the comparison that ends the loop.
	always_comb begin
		count_ext = CAP_W'(count_q);
		if (CAP_W'(iteration_cap) > CAP_W'(ITER_LIMIT)) begin
			cap = CAP_W'(ITER_LIMIT);
		end else begin
			cap = CAP_W'(iteration_cap);
		end
		cap_hit = (count_ext >= cap);
	end

	// Floored products back in Q4.28 and the escape test.
	always_comb begin
		zx2     = WIDE_W'(pxx_q >>> Q_FRAC);
		zy2     = WIDE_W'(pyy_q >>> Q_FRAC);
		zxy2    = WIDE_W'(pxy_q >>> (Q_FRAC - 1));
		mag     = zx2 + zy2;
		escaped = (mag > ESCAPE_BOUND);
	end

	assign sts = '{cap_hit: cap_hit, escaped: escaped};

	// Palette index: quotient by reciprocal, then one correction step.
	always_comb begin
		pal_sum    = SUM_W'(count_ext) + SUM_W'(palette_shift);
		recip_prod = PROD_W'(pal_sum) * PROD_W'(RECIP);
		if (r0_q >= SUM_W'(PALETTE_ENTRIES)) begin
			pal_idx = r0_q - SUM_W'(PALETTE_ENTRIES);
		end else begin
			pal_idx = r0_q;
		end
	end

	// Start point: capture, multiply by the steps, then add and saturate.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			px_q <= pixel_x;
			py_q <= pixel_y;
		end
		if (cmd.start_mul) begin
			prodx_q <= $signed({1'b0, px_q}) * x_step;
			prody_q <= $signed({1'b0, py_q}) * y_step;
		end
		if (cmd.start_load) begin
			zx_q <= sat_q(WIDE_W'(prodx_q) + WIDE_W'(x_min));
			zy_q <= sat_q(WIDE_W'(prody_q) + WIDE_W'(y_min));
		end else if (cmd.iter_step) begin
			zx_q <= sat_q(zx2 - zy2 + WIDE_W'(c_real));
			zy_q <= sat_q(zxy2 + WIDE_W'(c_imag));
		end
		if (cmd.iter_mul) begin
			pxx_q <= zx_q * zx_q;
			pyy_q <= zy_q * zy_q;
			pxy_q <= zx_q * zy_q;
		end
	end

	// Iteration counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.start_load) begin
			count_q <= '0;
		end else if (cmd.iter_step) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Colour index fold and result register.
	// The quotient is taken with the sum, the remainder before correction in the next cycle.
	always_ff @(posedge clk) begin
		if (cmd.pal_sum) begin
			inside_q <= cap_hit;
			n_q      <= pal_sum;
			q_q      <= SUM_W'(recip_prod >> RK);
		end
		if (cmd.pal_fold) begin
			r0_q <= n_q - q_q * SUM_W'(PALETTE_ENTRIES);
		end
		if (cmd.emit) begin
			escape_count_q <= count_ext[7:0];
			inside_set_q   <= inside_q;
			pixel_argb_q   <= inside_q ? ARGB_BLACK : COLOUR_ROM[pal_idx[7:0]];
		end
	end

	assign escape_count = escape_count_q;
	assign pixel_argb   = pixel_argb_q;
	assign inside_set   = inside_set_q;

	// An iteration step only runs below the cap.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.iter_step |-> (count_ext < cap))
		else $error("iteration step at or above the cap");

	// Loading a start point clears the counter.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_load |=> (count_q == '0))
		else $error("counter not cleared at start point");

	// The folded palette index is in range when the colour is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && !inside_q) |-> (pal_idx < SUM_W'(PALETTE_ENTRIES)))
		else $error("palette index out of range");

endmodule
